### hw/rtl/phc_pkg.sv
package phc_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_TARGET_HEADING = 3'd0;
    localparam logic [2:0] CFG_TURN_REVERSE   = 3'd1;
    localparam logic [2:0] CFG_GAIN_P         = 3'd2;
    localparam logic [2:0] CFG_GAIN_I         = 3'd3;
    localparam logic [2:0] CFG_GAIN_D         = 3'd4;
    localparam logic [2:0] CFG_INT_WINDOW     = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd6;
    localparam logic [2:0] CFG_USE_MAGNITUDE  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default drive limits in wheel power units.
    localparam logic signed [7:0] BRAKE_LEVEL_DEF = 8'sd10;
    localparam logic signed [7:0] POWER_LIMIT_DEF = 8'sd127;

    typedef struct packed {
        logic [15:0] target_heading;
        logic        turn_reverse;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [14:0] integral_window;
        logic [15:0] timeout_ms;
        logic        use_magnitude;
    } t_cfg;

    // Error stage result: signed values carried as raw two's complement bits.
    typedef struct packed {
        logic        brake;
        logic [16:0] err;
        logic [17:0] diff;
        logic [31:0] integ;
    } t_err_stage;

    // Product stage result.
    typedef struct packed {
        logic        brake;
        logic [33:0] prod_p;
        logic [48:0] prod_i;
        logic [34:0] prod_d;
    } t_prod_stage;

endpackage

### hw/rtl/phc_err.sv
module phc_err (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  phc_pkg::t_cfg             i_cfg,
    input  logic                      i_load,
    input  logic                      i_valid,
    input  logic                      i_kind,
    input  logic [15:0]               i_heading,
    input  logic [15:0]               i_elapsed_ms,
    output logic                      o_valid,
    output phc_pkg::t_err_stage       o_stage
);
    import phc_pkg::*;

    logic        r_running;
    logic        r_expired;
    logic [16:0] r_prev_err;
    logic [31:0] r_integral;
    logic        r_valid;
    t_err_stage  r_stage;

    logic        w_fire;
    logic        w_brake;
    logic        w_run;
    logic [16:0] w_prev_base;
    logic [31:0] w_int_base;
    logic [16:0] w_head;
    logic [16:0] w_pos;
    logic [16:0] w_err;
    logic [17:0] w_diff;
    logic [16:0] w_mag;
    logic        w_in_window;
    logic [32:0] w_sum;
    logic [31:0] w_sum_sat;
    logic [31:0] w_int_new;
    logic        w_expire;

    assign w_fire  = i_load & i_valid;
    // A pending brake takes the next item, whatever its kind.
    assign w_brake = r_running & r_expired;
    assign w_run   = r_running | i_kind;

    // A start sample sees cleared history.
    assign w_prev_base = i_kind ? 17'd0 : r_prev_err;
    assign w_int_base  = i_kind ? 32'd0 : r_integral;

    assign w_head = {i_heading[15], i_heading};
    assign w_pos  = (i_cfg.use_magnitude && i_heading[15]) ? (17'd0 - w_head) : w_head;
    assign w_err  = {i_cfg.target_heading[15], i_cfg.target_heading} - w_pos;
    assign w_diff = {w_err[16], w_err} - {w_prev_base[16], w_prev_base};

    // The magnitude is read as unsigned, so the most negative error stays large.
    assign w_mag       = w_err[16] ? (17'd0 - w_err) : w_err;
    assign w_in_window = w_mag < {2'b00, i_cfg.integral_window};

    assign w_sum = {w_int_base[31], w_int_base} + {{16{w_err[16]}}, w_err};

    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sum_sat = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_sum_sat = w_sum[31:0];
        end
    end

    assign w_int_new = w_in_window ? w_sum_sat : 32'd0;
    assign w_expire  = i_elapsed_ms >= i_cfg.timeout_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_expired  <= 1'b0;
            r_prev_err <= 17'd0;
            r_integral <= 32'd0;
            r_valid    <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= w_fire & (w_brake | w_run);
            end
            if (w_fire) begin
                if (w_brake) begin
                    r_running <= 1'b0;
                    r_expired <= 1'b0;
                end else if (w_run) begin
                    r_running  <= 1'b1;
                    r_expired  <= w_expire;
                    r_prev_err <= w_err;
                    r_integral <= w_int_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.brake <= w_brake;
            r_stage.err   <= w_err;
            r_stage.diff  <= w_diff;
            r_stage.integ <= w_int_new;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

    a_idle_not_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_expired)
        else $error("brake pending while no turn is running");

    a_brake_ends_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_brake) |=> (!r_running && r_valid && r_stage.brake))
        else $error("brake item did not end the turn");

endmodule

### hw/rtl/phc_mul.sv
module phc_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  phc_pkg::t_cfg             i_cfg,
    input  logic                      i_load,
    input  logic                      i_valid,
    input  phc_pkg::t_err_stage       i_stage,
    output logic                      o_valid,
    output phc_pkg::t_prod_stage      o_stage
);
    import phc_pkg::*;

    logic               r_valid;
    t_prod_stage        r_stage;
    logic signed [33:0] w_prod_p;
    logic signed [48:0] w_prod_i;
    logic signed [34:0] w_prod_d;

    // Gains are unsigned Q8.8; a zero sign bit makes them signed operands.
    assign w_prod_p = $signed({1'b0, i_cfg.gain_p}) * $signed(i_stage.err);
    assign w_prod_i = $signed({1'b0, i_cfg.gain_i}) * $signed(i_stage.integ);
    assign w_prod_d = $signed({1'b0, i_cfg.gain_d}) * $signed(i_stage.diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.brake  <= i_stage.brake;
            r_stage.prod_p <= w_prod_p;
            r_stage.prod_i <= w_prod_i;
            r_stage.prod_d <= w_prod_d;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### hw/rtl/phc_out.sv
module phc_out #(
    parameter logic signed [7:0] BRAKE_LEVEL = phc_pkg::BRAKE_LEVEL_DEF,
    parameter logic signed [7:0] POWER_LIMIT = phc_pkg::POWER_LIMIT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  phc_pkg::t_cfg             i_cfg,
    input  logic                      i_load,
    input  logic                      i_valid,
    input  phc_pkg::t_prod_stage      i_stage,
    output logic                      o_valid,
    output logic signed [7:0]         o_left_power,
    output logic signed [7:0]         o_right_power,
    output logic                      o_braking
);
    import phc_pkg::*;

    localparam logic signed [41:0] LIM_HI = 42'(POWER_LIMIT);
    localparam logic signed [41:0] LIM_LO = -42'(POWER_LIMIT);

    logic               r_valid;
    logic signed [7:0]  r_left;
    logic signed [7:0]  r_right;
    logic               r_braking;

    logic signed [49:0] w_sum;
    logic signed [41:0] w_shift;
    logic signed [41:0] w_quot;
    logic signed [7:0]  w_power;
    logic signed [7:0]  w_left;

    assign w_sum = 50'($signed(i_stage.prod_p)) + 50'($signed(i_stage.prod_i))
                 + 50'($signed(i_stage.prod_d));

    // Divide by 256 with truncation toward zero.
    assign w_shift = w_sum[49:8];
    assign w_quot  = (w_sum[49] && (w_sum[7:0] != 8'd0)) ? (w_shift + 42'sd1) : w_shift;

    always_comb begin
        if (w_quot > LIM_HI) begin
            w_power = POWER_LIMIT;
        end else if (w_quot < LIM_LO) begin
            w_power = -POWER_LIMIT;
        end else begin
            w_power = w_quot[7:0];
        end
    end

    // The left wheel follows the turn direction; the right wheel mirrors it.
    always_comb begin
        if (i_stage.brake) begin
            w_left = i_cfg.turn_reverse ? BRAKE_LEVEL : -BRAKE_LEVEL;
        end else begin
            w_left = i_cfg.turn_reverse ? -w_power : w_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left    <= w_left;
            r_right   <= -w_left;
            r_braking <= i_stage.brake;
        end
    end

    assign o_valid       = r_valid;
    assign o_left_power  = r_left;
    assign o_right_power = r_right;
    assign o_braking     = r_braking;

endmodule

### hw/rtl/pid_heading_controller_top.sv
// PID heading controller for a timed point turn. Each request on the input
// channel is one gyro heading sample with the milliseconds elapsed in the turn;
// a sample with kind set starts a new turn and clears the controller history.
// The block answers each sample of a running turn with one pair of opposite
// wheel powers, kp*e + ki*sum + kd*(e - last_e) scaled by 1/256 (Q8.8 gains),
// truncated toward zero and limited to +-POWER_LIMIT (127 by default), where
// the integral only builds up while the error magnitude stays below the
// configured window. Once a sample reaches the configured timeout, the next
// request of either kind is answered with a single brake command of power
// BRAKE_LEVEL (10 by default, braking set) and the block goes idle; ordinary
// samples while idle are dropped without a result.
// The block takes one request per clock cycle while no stall holds it back,
// and passes each request through these registers in order: an input register,
// the error and integral stage (which closes the only state loop), the
// product stage with its three multipliers, and the output register that sums
// and limits. Each stage holds its request only while the stage behind it is
// stalled, so bubbles close up and the input keeps flowing while a result
// waits, until every stage is full. Configuration registers are written through
// a plain write port and must only be changed while no request is in flight.
module pid_heading_controller_top #(
    parameter logic signed [7:0] BRAKE_LEVEL = phc_pkg::BRAKE_LEVEL_DEF,
    parameter logic signed [7:0] POWER_LIMIT = phc_pkg::POWER_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [phc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [phc_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic signed [15:0]              i_heading,
    input  logic [15:0]                     i_elapsed_ms,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [7:0]               o_left_power,
    output logic signed [7:0]               o_right_power,
    output logic                            o_braking
);
    import phc_pkg::*;

    t_cfg        r_cfg;

    // Input register.
    logic        r_in_valid;
    logic        r_kind;
    logic [15:0] r_heading;
    logic [15:0] r_elapsed;

    logic        w_err_valid;
    t_err_stage  w_err_stage;
    logic        w_prod_valid;
    t_prod_stage w_prod_stage;

    // Per-stage load enables: a stage may load when it is empty or the stage
    // behind it is loading too.
    logic        w_ld_out;
    logic        w_ld_prod;
    logic        w_ld_err;
    logic        w_ld_in;

    assign w_ld_out  = !o_out_valid || !i_out_stall;
    assign w_ld_prod = !w_prod_valid || w_ld_out;
    assign w_ld_err  = !w_err_valid || w_ld_prod;
    assign w_ld_in   = !r_in_valid || w_ld_err;

    assign o_in_stall = !w_ld_in;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_heading  <= 16'd0;
            r_cfg.turn_reverse    <= 1'b0;
            r_cfg.gain_p          <= 16'd0;
            r_cfg.gain_i          <= 16'd0;
            r_cfg.gain_d          <= 16'd0;
            r_cfg.integral_window <= 15'd0;
            r_cfg.timeout_ms      <= 16'd0;
            r_cfg.use_magnitude   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_HEADING: r_cfg.target_heading  <= i_cfg_data;
                CFG_TURN_REVERSE:   r_cfg.turn_reverse    <= i_cfg_data[0];
                CFG_GAIN_P:         r_cfg.gain_p          <= i_cfg_data;
                CFG_GAIN_I:         r_cfg.gain_i          <= i_cfg_data;
                CFG_GAIN_D:         r_cfg.gain_d          <= i_cfg_data;
                CFG_INT_WINDOW:     r_cfg.integral_window <= i_cfg_data[14:0];
                CFG_TIMEOUT_MS:     r_cfg.timeout_ms      <= i_cfg_data;
                CFG_USE_MAGNITUDE:  r_cfg.use_magnitude   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_ld_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_in) begin
            r_kind    <= i_kind;
            r_heading <= i_heading;
            r_elapsed <= i_elapsed_ms;
        end
    end

    phc_err u_err (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_load       (w_ld_err),
        .i_valid      (r_in_valid),
        .i_kind       (r_kind),
        .i_heading    (r_heading),
        .i_elapsed_ms (r_elapsed),
        .o_valid      (w_err_valid),
        .o_stage      (w_err_stage)
    );

    phc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_load  (w_ld_prod),
        .i_valid (w_err_valid),
        .i_stage (w_err_stage),
        .o_valid (w_prod_valid),
        .o_stage (w_prod_stage)
    );

    phc_out #(
        .BRAKE_LEVEL (BRAKE_LEVEL),
        .POWER_LIMIT (POWER_LIMIT)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_load        (w_ld_out),
        .i_valid       (w_prod_valid),
        .i_stage       (w_prod_stage),
        .o_valid       (o_out_valid),
        .o_left_power  (o_left_power),
        .o_right_power (o_right_power),
        .o_braking     (o_braking)
    );

    // The wheels always turn against each other.
    a_wheels_opposed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_left_power + o_right_power) == 8'sd0))
        else $error("wheel powers are not opposite");

    // Drive power never reaches the unused most negative code.
    a_power_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_power != -8'sd128))
        else $error("wheel power outside the limit");

    // With nothing waiting at the output, the whole pipeline moves.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the output is empty");

endmodule

### test/pid_heading_controller_top_test.sv
module pid_heading_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import phc_pkg::*;

    // The run is stopped as failed if it is still going after this many cycles.
    localparam int CYCLE_LIMIT = 50_000;

    // Idle and stall rate of both channels, in percent.
    localparam int IDLE_PCT = 18;

    // Cycles the pipeline needs to empty out when a request made no command.
    localparam int DRAIN_CYCLES = 8;

    // One wheel command as the block delivers it.
    typedef struct {
        logic signed [7:0] left_pw;
        logic signed [7:0] right_pw;
        logic              brake;
    } t_drive_cmd;

    // Keeps its own copy of the controller settings and history, works out the
    // wheel command that each accepted sample must cause, and compares the
    // commands that come out against them in order.
    class t_drive_scoreboard;
        int         target_hdg;
        bit         reverse;
        int         gain_p;
        int         gain_i;
        int         gain_d;
        int         window;
        int         timeout;
        bit         use_mag;

        int         prev_err;
        int         err_sum;
        bit         running;
        bit         expired;

        t_drive_cmd pending_cmds[$];
        int         failures;
        int         reports;

        function new();
            target_hdg = 0;
            reverse    = 1'b0;
            gain_p     = 0;
            gain_i     = 0;
            gain_d     = 0;
            window     = 0;
            timeout    = 0;
            use_mag    = 1'b1;
            prev_err   = 0;
            err_sum    = 0;
            running    = 1'b0;
            expired    = 1'b0;
            failures   = 0;
            reports    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TARGET_HEADING: target_hdg = int'($signed(data));
                CFG_TURN_REVERSE:   reverse    = data[0];
                CFG_GAIN_P:         gain_p     = int'(data);
                CFG_GAIN_I:         gain_i     = int'(data);
                CFG_GAIN_D:         gain_d     = int'(data);
                CFG_INT_WINDOW:     window     = int'(data[14:0]);
                CFG_TIMEOUT_MS:     timeout    = int'(data);
                CFG_USE_MAGNITUDE:  use_mag    = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic kind, logic signed [15:0] heading,
                                  logic [15:0] elapsed);
            int         dir;
            int         pos;
            int         err;
            int         diff;
            int         mag;
            int         power;
            longint     acc;
            t_drive_cmd cmd;

            dir = reverse ? -1 : 1;

            // A pending brake swallows the next request whatever its kind.
            if (running && expired) begin
                running = 1'b0;
                expired = 1'b0;
                cmd.left_pw  = 8'(-dir * int'(BRAKE_LEVEL_DEF));
                cmd.right_pw = 8'(dir * int'(BRAKE_LEVEL_DEF));
                cmd.brake    = 1'b1;
                pending_cmds.push_back(cmd);
                return;
            end
            if (kind) begin
                prev_err = 0;
                err_sum  = 0;
                expired  = 1'b0;
                running  = 1'b1;
            end
            if (!running)
                return;

            pos = int'(heading);
            if (use_mag && pos < 0)
                pos = -pos;
            err      = target_hdg - pos;
            diff     = err - prev_err;
            prev_err = err;

            mag = (err < 0) ? -err : err;
            if (mag < window) begin
                acc = longint'(err_sum) + longint'(err);
                if (acc > longint'(32'sh7FFF_FFFF))
                    acc = longint'(32'sh7FFF_FFFF);
                if (acc < longint'(32'sh8000_0000))
                    acc = longint'(32'sh8000_0000);
                err_sum = int'(acc);
            end else begin
                err_sum = 0;
            end

            acc = longint'(gain_p) * err + longint'(gain_i) * err_sum
                + longint'(gain_d) * diff;
            acc = acc / 256;
            if (acc > int'(POWER_LIMIT_DEF))
                acc = int'(POWER_LIMIT_DEF);
            if (acc < -int'(POWER_LIMIT_DEF))
                acc = -int'(POWER_LIMIT_DEF);
            power = int'(acc);

            if (int'(elapsed) >= timeout)
                expired = 1'b1;

            cmd.left_pw  = 8'(power * dir);
            cmd.right_pw = 8'(-power * dir);
            cmd.brake    = 1'b0;
            pending_cmds.push_back(cmd);
        endfunction

        function void check_command(logic signed [7:0] left_pw, logic signed [7:0] right_pw,
                                    logic brake);
            t_drive_cmd want;

            if (pending_cmds.size() == 0) begin
                failures++;
                if (reports < 10) begin
                    reports++;
                    $display("%0t: unexpected command left %0d right %0d braking %0b",
                             $time, left_pw, right_pw, brake);
                end
                return;
            end
            want = pending_cmds.pop_front();
            if (left_pw !== want.left_pw || right_pw !== want.right_pw
                    || brake !== want.brake) begin
                failures++;
                if (reports < 10) begin
                    reports++;
                    $display("%0t: command differs: expected left %0d right %0d braking %0b,",
                             $time, want.left_pw, want.right_pw, want.brake);
                    $display("    got left %0d right %0d braking %0b",
                             left_pw, right_pw, brake);
                end
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_TARGET_HEADING;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic                   i_kind        = 1'b0;
    logic signed [15:0]     i_heading     = '0;
    logic [15:0]            i_elapsed_ms  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic signed [7:0]      o_left_power;
    logic signed [7:0]      o_right_power;
    logic                   o_braking;

    t_drive_scoreboard board = new();

    // When set, neither side idles: the sender offers a request every cycle and
    // the receiver never stalls.
    bit calm = 1'b0;

    int cycle_count = 0;

    pid_heading_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_heading     (i_heading),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_power  (o_left_power),
        .o_right_power (o_right_power),
        .o_braking     (o_braking)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that hangs on a handshake ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pid_heading_controller_top: mismatch");
        $finish;
    end

    // Both monitors sample at the rising edge, before any of this edge's
    // nonblocking updates land, so they see exactly what the block sees.
    // A request accepted on the input side gets its command predicted here.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_sample(i_kind, i_heading, i_elapsed_ms);
    end

    // Every command accepted on the output side is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_command(o_left_power, o_right_power, o_braking);
    end

    // The receiver stalls at random, one cycle decision at a time, so stalls
    // land on every stage of the pipeline.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Offers one sample request and returns at the edge where it is taken.
    // Valid stays high on return so back-to-back requests need no bubble; each
    // cycle of a random gap lowers it first. The payload holds still while
    // stalled.
    task automatic send_sample(input logic kind, input logic [15:0] heading,
                               input logic [15:0] elapsed);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_heading    <= heading;
        i_elapsed_ms <= elapsed;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Stops sending and waits until every predicted command has been seen,
    // then gives the pipeline time to flush requests that make no command.
    // The first edge lets the input monitor record the last request.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Writes all eight registers. The bits above a narrow register's width
    // carry random junk, which the block has to ignore.
    task automatic load_setting(input int target, input bit rev, input int gp,
                                input int gi, input int gd, input int win,
                                input int tmo, input bit mag);
        write_reg(CFG_TARGET_HEADING, 16'(target));
        write_reg(CFG_TURN_REVERSE, {15'($urandom), rev});
        write_reg(CFG_GAIN_P, 16'(gp));
        write_reg(CFG_GAIN_I, 16'(gi));
        write_reg(CFG_GAIN_D, 16'(gd));
        write_reg(CFG_INT_WINDOW, {1'($urandom), 15'(win)});
        write_reg(CFG_TIMEOUT_MS, 16'(tmo));
        write_reg(CFG_USE_MAGNITUDE, {15'($urandom), mag});
        i_cfg_we <= 1'b0;
    endtask

    // Gains are mostly small so that the power often stays inside the limit,
    // with the extremes and full-range values mixed in.
    function automatic int pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 30)
            return 65535;
        if (r < 75)
            return $urandom_range(0, 768);
        return $urandom_range(0, 65535);
    endfunction

    // Most headings land near the target, within a little more than the
    // integral window, so the integral both builds up and gets cleared. In
    // magnitude mode some of them are mirrored to negative values.
    function automatic logic [15:0] pick_heading(input int target, input int win,
                                                 input bit mag);
        int r;
        int h;
        r = $urandom_range(99);
        if (r < 8) begin
            case ($urandom_range(3))
                0:       h = -32768;
                1:       h = 32767;
                2:       h = 0;
                default: h = -1;
            endcase
        end else if (r < 30) begin
            h = int'($signed(16'($urandom)));
        end else begin
            h = target + int'($urandom_range(0, 2 * win + 16)) - (win + 8);
            if (h > 32767)
                h = 32767;
            if (h < -32768)
                h = -32768;
            if (mag && $urandom_range(1) && h > -32768)
                h = -h;
        end
        return 16'(h);
    endfunction

    initial begin
        int phase;
        int phase_items;
        int el;
        int tmo;
        int tgt;
        int win;
        bit mag;
        int n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero gains and a zero timeout, so the first sample
        // drives with zero power and the one after it brakes.
        send_sample(1'b1, 16'sd7, 16'd0);
        send_sample(1'b0, 16'sd7, 16'd0);

        // Ordinary sample while idle is dropped, heading extremes in magnitude
        // mode, a restart in the middle of a turn, then the timeout and brake.
        settle();
        load_setting(1000, 1'b0, 256, 16, 128, 200, 100, 1'b1);
        send_sample(1'b0, 16'sd5, 16'd0);
        send_sample(1'b1, 16'sh8000, 16'd0);
        send_sample(1'b0, 16'sh7FFF, 16'd10);
        send_sample(1'b0, 16'sd950, 16'd20);
        send_sample(1'b0, -16'sd990, 16'd30);
        send_sample(1'b1, 16'sd1000, 16'd0);
        send_sample(1'b0, 16'sd0, 16'hFFFF);
        send_sample(1'b0, 16'sd123, 16'd0);
        send_sample(1'b0, 16'sd0, 16'd0);

        // Maximum gains with reversed turn and signed heading; zero timeout
        // makes every start expire at once, and a start request takes the brake.
        settle();
        load_setting(-32768, 1'b1, 65535, 65535, 65535, 32767, 0, 1'b0);
        send_sample(1'b1, 16'sh7FFF, 16'd0);
        send_sample(1'b1, 16'sd0, 16'd0);
        send_sample(1'b1, 16'sh8000, 16'hFFFF);
        send_sample(1'b0, 16'sd0, 16'd0);

        // Zero gains and a closed window; the timeout is only reached at the
        // last elapsed value.
        settle();
        load_setting(32767, 1'b0, 0, 0, 0, 0, 65535, 1'b1);
        send_sample(1'b1, 16'sh8000, 16'hFFFE);
        send_sample(1'b0, 16'sh7FFF, 16'hFFFF);
        send_sample(1'b0, 16'sd0, 16'd0);

        // Random turns under eight settings. The first two are the all-high and
        // all-low extremes; the fourth runs with no idling on either side.
        for (phase = 0; phase < 8; phase++) begin
            settle();
            if (phase == 0) begin
                tgt = 32767;
                win = 32767;
                tmo = 65535;
                mag = 1'b0;
                load_setting(tgt, 1'b1, 65535, 65535, 65535, win, tmo, mag);
            end else if (phase == 1) begin
                tgt = -32768;
                win = 0;
                tmo = 0;
                mag = 1'b1;
                load_setting(tgt, 1'b0, 0, 0, 0, win, tmo, mag);
            end else begin
                case ($urandom_range(3))
                    0:       tgt = -32768;
                    1:       tgt = 32767;
                    2:       tgt = int'($signed(16'($urandom)));
                    default: tgt = int'($urandom_range(0, 4000)) - 2000;
                endcase
                case ($urandom_range(3))
                    0:       win = 0;
                    1:       win = 32767;
                    2:       win = $urandom_range(0, 2000);
                    default: win = $urandom_range(0, 32767);
                endcase
                n = $urandom_range(99);
                if (n < 10)
                    tmo = 0;
                else if (n < 25)
                    tmo = 65535;
                else
                    tmo = $urandom_range(20, 3000);
                mag = $urandom_range(1);
                load_setting(tgt, $urandom_range(1), pick_gain(), pick_gain(),
                             pick_gain(), win, tmo, mag);
            end
            calm = (phase == 3);

            phase_items = 0;
            while (phase_items < 150) begin
                // Noise: a stray ordinary sample, usually dropped while idle,
                // but it takes the brake if the last turn was left unfinished.
                if ($urandom_range(99) < 25)
                    send_sample(1'b0, pick_heading(tgt, win, mag), 16'($urandom));

                el = $urandom_range(0, 20);
                send_sample(1'b1, pick_heading(tgt, win, mag), 16'(el));
                phase_items++;

                // Samples with growing elapsed time until the timeout is hit,
                // now and then restarting the turn on the way.
                while (el < tmo) begin
                    el = el + int'($urandom_range(1, tmo / 6 + 1));
                    if (el > 65535)
                        el = 65535;
                    send_sample($urandom_range(99) < 4, pick_heading(tgt, win, mag),
                                16'(el));
                    phase_items++;
                end

                // Usually the request that collects the brake; some turns are
                // left unfinished so the brake falls on whatever comes next.
                if ($urandom_range(99) < 88) begin
                    send_sample($urandom_range(1), pick_heading(tgt, win, mag),
                                16'($urandom));
                    phase_items++;
                end
            end
        end
        calm = 1'b0;

        settle();
        if (board.failures == 0 && board.pending_cmds.size() == 0)
            $display("pid_heading_controller_top: match");
        else
            $display("pid_heading_controller_top: mismatch");
        $finish;
    end

endmodule
